[sv/prhc_pkg.sv]
// Shared types and constants for the probabilistic-replacement hash cache.
package prhc_pkg;

	// Default parameter values
	localparam int TABLE_DEPTH_DEF   = 1024;
	localparam int KEY_MAX_BYTES_DEF = 8;
	localparam int DATA_BITS_DEF     = 64;

	// Fixed field widths
	localparam int HASH_W   = 64;
	localparam int KEY_IN_W = 64;
	localparam int LEN_W    = 4;
	localparam int WORD_IO_W = 64;
	localparam int RAND_W   = 32;
	localparam int PROB_W   = 32;
	localparam int ENT_W    = 11;
	localparam int CFG_W    = 32;
	localparam int CNT64_W  = 64;

	// Command codes
	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_INSERT = 1'b1;

	// Register indexes
	localparam logic REG_REPLACE_PROB   = 1'b0;
	localparam logic REG_ENTRIES_IN_USE = 1'b1;

	typedef struct packed {
		logic                 cmd;
		logic [HASH_W-1:0]    hash_value;
		logic [KEY_IN_W-1:0]  key_bytes;
		logic [LEN_W-1:0]     key_len;
		logic [WORD_IO_W-1:0] payload;
		logic [RAND_W-1:0]    rand_word;
	} in_item_t;

	typedef struct packed {
		logic                 found;
		logic [WORD_IO_W-1:0] read_data;
		logic                 stored;
		logic [CNT64_W-1:0]   access_count;
		logic [CNT64_W-1:0]   hit_count;
	} out_item_t;

	// Status of the remainder unit
	typedef struct packed {
		logic busy;
		logic done;
	} mod_stat_t;

endpackage

[sv/prhc_mod_unit.sv]
// Bit-serial remainder unit: 64-bit hash modulo the slot count.
module prhc_mod_unit #(
	parameter int TABLE_DEPTH = prhc_pkg::TABLE_DEPTH_DEF,
	parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [prhc_pkg::HASH_W-1:0] dividend,
	input  logic [CNT_W-1:0]            divisor,
	output prhc_pkg::mod_stat_t         stat,
	output logic [CNT_W-1:0]            rem
);

	localparam int STEP_W = $clog2(prhc_pkg::HASH_W);

	logic [prhc_pkg::HASH_W-1:0] dvd_q;
	logic [CNT_W-1:0]            rem_q;
	logic [CNT_W-1:0]            div_q;
	logic [STEP_W-1:0]           step_q;
	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W:0]              shifted;
	logic [CNT_W+1:0]            diff;

	// Shift in the next dividend bit and trial-subtract the divisor
	assign shifted = {rem_q, dvd_q[prhc_pkg::HASH_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(prhc_pkg::HASH_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Payload of the iteration
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[prhc_pkg::HASH_W-2:0], 1'b0};
			rem_q <= diff[CNT_W+1] ? shifted[CNT_W-1:0] : diff[CNT_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign rem       = rem_q;

endmodule

[sv/prhc_table.sv]
// Slot store: one write port, one registered read port.
module prhc_table #(
	parameter int DEPTH  = prhc_pkg::TABLE_DEPTH_DEF,
	parameter int WORD_W = 1 + prhc_pkg::LEN_W + 8 * prhc_pkg::KEY_MAX_BYTES_DEF
		+ prhc_pkg::DATA_BITS_DEF,
	parameter int IDX_W  = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [IDX_W-1:0]  waddr,
	input  logic [WORD_W-1:0] wdata,
	input  logic [IDX_W-1:0]  raddr,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/probabilistic_replace_hash_cache_top.sv]
// Top level of the direct-mapped hash cache with probabilistic replacement.
// After reset the block sweeps the slot store once to clear every valid bit,
// one slot per cycle, with in_ready held low until the sweep ends; config
// writes are taken meanwhile. Each request then passes through the bit-serial
// remainder unit reducing hash_value modulo the slot count, one bit per
// cycle, then the registered store read, the compare that updates the slot
// and counters, and the load of the output register, after which in_ready is
// high again. in_ready and out_valid both rise with that load, which waits
// on out_ready while the previous result is still held. One request is
// worked on at a time; a finished result sits in the output register while
// the next request is accepted.
module probabilistic_replace_hash_cache_top #(
	parameter int TABLE_DEPTH   = prhc_pkg::TABLE_DEPTH_DEF,
	parameter int KEY_MAX_BYTES = prhc_pkg::KEY_MAX_BYTES_DEF,
	parameter int DATA_BITS     = prhc_pkg::DATA_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  prhc_pkg::in_item_t         in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output prhc_pkg::out_item_t        out_data,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [prhc_pkg::CFG_W-1:0] cfg_wdata
);

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W  = 8 * KEY_MAX_BYTES;
	localparam int LEN_W  = prhc_pkg::LEN_W;
	localparam int WORD_W = 1 + LEN_W + KEY_W + DATA_BITS;

	// Sequencer states
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_CMP   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]                  state_q;
	logic [IDX_W-1:0]            clr_q;
	logic [prhc_pkg::PROB_W-1:0] prob_q;
	logic [prhc_pkg::ENT_W-1:0]  ent_q;

	logic                        cmd_q;
	logic [KEY_W-1:0]            key_q;
	logic [LEN_W-1:0]            len_q;
	logic [DATA_BITS-1:0]        data_q;
	logic [prhc_pkg::RAND_W-1:0] rnd_q;
	logic [IDX_W-1:0]            idx_q;

	logic [prhc_pkg::CNT64_W-1:0] access_q;
	logic [prhc_pkg::CNT64_W-1:0] hits_q;
	prhc_pkg::out_item_t          pend_q;
	prhc_pkg::out_item_t          out_q;
	logic                         out_valid_q;

	logic                         accept;
	logic [LEN_W-1:0]             len_c;
	logic [prhc_pkg::KEY_IN_W-1:0] key_m;
	logic [CNT_W-1:0]             modulus;
	prhc_pkg::mod_stat_t          mod_stat;
	logic [CNT_W-1:0]             mod_rem;

	logic                         tbl_we;
	logic [IDX_W-1:0]             tbl_waddr;
	logic [WORD_W-1:0]            tbl_wdata;
	logic [WORD_W-1:0]            tbl_rdata;

	logic                         rd_valid;
	logic [LEN_W-1:0]             rd_len;
	logic [KEY_W-1:0]             rd_key;
	logic [DATA_BITS-1:0]         rd_data;
	logic [prhc_pkg::PROB_W-1:0]  thresh;
	logic                         hit;
	logic                         do_store;
	logic                         out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prob_q <= '0;
			ent_q  <= prhc_pkg::ENT_W'(1024);
		end else if (cfg_we) begin
			unique case (cfg_index)
				prhc_pkg::REG_REPLACE_PROB:   prob_q <= cfg_wdata[prhc_pkg::PROB_W-1:0];
				prhc_pkg::REG_ENTRIES_IN_USE: ent_q  <= cfg_wdata[prhc_pkg::ENT_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the key length and zero the bytes past it
	always_comb begin
		if (32'(in_data.key_len) > 32'(KEY_MAX_BYTES)) begin
			len_c = LEN_W'(KEY_MAX_BYTES);
		end else begin
			len_c = in_data.key_len;
		end
		for (int b = 0; b < 8; b++) begin
			key_m[b*8 +: 8] = (LEN_W'(b) < len_c) ? in_data.key_bytes[b*8 +: 8] : 8'h00;
		end
	end

	// Slot count used as modulus: zero acts as one, too large acts as the depth
	always_comb begin
		if (ent_q == '0) begin
			modulus = CNT_W'(1);
		end else if (32'(ent_q) > 32'(TABLE_DEPTH)) begin
			modulus = CNT_W'(TABLE_DEPTH);
		end else begin
			modulus = CNT_W'(ent_q);
		end
	end

	prhc_mod_unit #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.CNT_W       (CNT_W)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.dividend (in_data.hash_value),
		.divisor  (modulus),
		.stat     (mod_stat),
		.rem      (mod_rem)
	);

	prhc_table #(
		.DEPTH  (TABLE_DEPTH),
		.WORD_W (WORD_W),
		.IDX_W  (IDX_W)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (mod_rem[IDX_W-1:0]),
		.rdata (tbl_rdata)
	);

	// Unpack the slot read back from the store
	assign rd_valid = tbl_rdata[WORD_W-1];
	assign rd_len   = tbl_rdata[DATA_BITS+KEY_W +: LEN_W];
	assign rd_key   = tbl_rdata[DATA_BITS +: KEY_W];
	assign rd_data  = tbl_rdata[DATA_BITS-1:0];

	// Hit and replacement decision
	assign thresh   = ~prob_q;
	assign hit      = (cmd_q == prhc_pkg::CMD_LOOKUP) && rd_valid
		&& (rd_len == len_q) && (rd_key == key_q);
	assign do_store = (cmd_q == prhc_pkg::CMD_INSERT)
		&& (!rd_valid || (thresh == '0) || (thresh <= rnd_q));

	// Store write: clearing sweep or slot update
	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = idx_q;
		tbl_wdata = {1'b1, len_q, key_q, data_q};
		if (state_q == ST_CLEAR) begin
			tbl_we    = 1'b1;
			tbl_waddr = clr_q;
			tbl_wdata = '0;
		end else if (state_q == ST_CMP) begin
			tbl_we = do_store;
		end
	end

	// Sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			access_q    <= '0;
			hits_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Raise the output flag on a load, drop it once the result is taken
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(TABLE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (mod_stat.done) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (cmd_q == prhc_pkg::CMD_LOOKUP) begin
						access_q <= access_q + 1'b1;
						if (hit) begin
							hits_q <= hits_q + 1'b1;
						end
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the request and build the result
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= in_data.cmd;
			key_q  <= key_m[KEY_W-1:0];
			len_q  <= len_c;
			data_q <= in_data.payload[DATA_BITS-1:0];
			rnd_q  <= in_data.rand_word;
		end
		if (mod_stat.done) begin
			idx_q <= mod_rem[IDX_W-1:0];
		end
		if (state_q == ST_CMP) begin
			pend_q.found        <= hit;
			pend_q.read_data    <= hit ? prhc_pkg::WORD_IO_W'(rd_data) : '0;
			pend_q.stored       <= do_store;
			pend_q.access_count <= (cmd_q == prhc_pkg::CMD_LOOKUP) ? access_q + 1'b1 : access_q;
			pend_q.hit_count    <= hit ? hits_q + 1'b1 : hits_q;
		end
		if (state_q == ST_DONE && out_free) begin
			out_q <= pend_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// An accepted request starts the remainder unit
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_DIV) && mod_stat.busy)
		else $error("remainder unit not started on accepted request");

	// The remainder unit finishes only while the sequencer waits for it
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		mod_stat.done |-> (state_q == ST_DIV))
		else $error("remainder done outside divide state");

	// The store is written only by the clearing sweep or a slot update
	a_write: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_we |-> (state_q == ST_CLEAR) || (state_q == ST_CMP))
		else $error("unexpected store write");

	// A result is loaded only when the output register is free
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && out_valid_q && !out_ready |=> (state_q == ST_DONE))
		else $error("result overwrote a pending output");

endmodule
